// ===== hw/rtl/sps_pkg.sv =====
// Shared types, character constants and match words for the source pattern scanner.
package sps_pkg;

	localparam int WORD_BYTES = 18;

	typedef logic [WORD_BYTES*8-1:0] word_t;
	typedef logic [5:0]              found_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} sps_step_t;

	typedef enum logic [2:0] {
		GAP_NONE,
		GAP_PLAIN,
		GAP_BSLASH,
		GAP_BSLASH_CR,
		GAP_FOUND
	} gap_t;

	localparam found_t FLAG_DATE   = 6'b000001;
	localparam found_t FLAG_TIME   = 6'b000010;
	localparam found_t FLAG_STAMP  = 6'b000100;
	localparam found_t FLAG_INCL   = 6'b001000;
	localparam found_t FLAG_EMBED  = 6'b010000;
	localparam found_t FLAG_INCBIN = 6'b100000;

	localparam logic [7:0] CH_HASH   = "#";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_UNDER  = "_";

	localparam word_t W_DATE      = {"__DATE__", 80'h0};
	localparam word_t W_TIME      = {"__TIME__", 80'h0};
	localparam word_t W_STAMP     = {"__TIMESTAMP__", 40'h0};
	localparam word_t W_INCL      = {"__has_", "include", 40'h0};
	localparam word_t W_INCL_NEXT = {"__has_", "include_next"};
	localparam word_t W_EMBED     = {"__has_", "embed", 56'h0};

	localparam word_t      TM_WORDS [3] = '{W_DATE, W_TIME, W_STAMP};
	localparam logic [4:0] TM_LENS  [3] = '{5'd8, 5'd8, 5'd13};
	localparam found_t     TM_FOUND [3] = '{FLAG_DATE, FLAG_TIME, FLAG_STAMP};

	localparam word_t      BI_WORDS [3] = '{W_INCL, W_INCL_NEXT, W_EMBED};
	localparam logic [4:0] BI_LENS  [3] = '{5'd13, 5'd18, 5'd11};

	function automatic logic is_ident(input logic [7:0] c);
		return (c == CH_UNDER) || (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
	endfunction

	function automatic logic is_hspace(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	function automatic logic [7:0] char_at(input word_t w, input logic [4:0] i);
		logic [7:0] ch;
		ch = '0;
		for (int p = 0; p < WORD_BYTES; p++) begin
			if (i == 5'(p)) begin
				ch = w[(WORD_BYTES-1-p)*8 +: 8];
			end
		end
		return ch;
	endfunction

	function automatic gap_t gap_step(input gap_t g, input logic [7:0] c);
		gap_t r;
		r = GAP_NONE;
		if (g == GAP_BSLASH) begin
			if (c == CH_LF) begin
				r = GAP_PLAIN;
			end else if (c == CH_CR) begin
				r = GAP_BSLASH_CR;
			end
		end else if (g == GAP_BSLASH_CR && c == CH_LF) begin
			r = GAP_PLAIN;
		end else if (is_hspace(c)) begin
			r = GAP_PLAIN;
		end else if (c == CH_BSLASH) begin
			r = GAP_BSLASH;
		end else if (c == CH_LPAREN) begin
			r = GAP_FOUND;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/sps_scan_core.sv =====
// Matcher state and per-byte update for all six scanned constructs.
module sps_scan_core
	import sps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sps_step_t step,
	output found_t    found_final
);

	typedef enum logic [3:0] {
		EMB_IDLE,
		EMB_GAP,
		EMB_BSLASH,
		EMB_BSLASH_CR,
		EMB_E,
		EMB_EM,
		EMB_EMB,
		EMB_EMBE,
		EMB_EMBED
	} emb_t;

	typedef enum logic [3:0] {
		INC_IDLE,
		INC_DOT,
		INC_I,
		INC_IN,
		INC_INC,
		INC_INCB,
		INC_INCBI,
		INC_INCBIN,
		INC_BSLASH
	} inc_t;

	found_t     found_q, found_n;
	logic       prev_q;
	logic [2:0] tm_alive_q, tm_alive_n;
	logic [3:0] tm_len_q, tm_len_n;
	logic [2:0] bi_alive_q, bi_alive_n;
	logic [4:0] bi_len_q, bi_len_n;
	gap_t       bi_gap_q, bi_gap_n;
	emb_t       emb_q, emb_n;
	inc_t       inc_q, inc_n;

	logic       c_id;
	logic       fresh;
	logic [7:0] c;
	logic [2:0] tm_base_alive, tm_hit;
	logic [3:0] tm_base_len;
	logic [2:0] bi_base_alive, bi_hit;
	logic [4:0] bi_base_len;
	logic       bi_complete;
	found_t     bi_kind;
	gap_t       gap_r;
	logic       gap_apply;
	found_t     tm_fin_n;

	assign bi_complete = (bi_alive_q[0] && bi_len_q == BI_LENS[0])
		|| (bi_alive_q[1] && bi_len_q == BI_LENS[1])
		|| (bi_alive_q[2] && bi_len_q == BI_LENS[2]);
	assign bi_kind = bi_alive_q[2] ? FLAG_EMBED : FLAG_INCL;

	always_comb begin
		c     = step.data;
		c_id  = is_ident(c);
		fresh = !prev_q;
		found_n = found_q;

		tm_base_alive = fresh ? 3'b111 : tm_alive_q;
		tm_base_len   = fresh ? 4'd0 : tm_len_q;
		for (int k = 0; k < 3; k++) begin
			tm_hit[k] = tm_base_alive[k] && ({1'b0, tm_base_len} < TM_LENS[k])
				&& (char_at(TM_WORDS[k], {1'b0, tm_base_len}) == c);
		end
		tm_alive_n = '0;
		tm_len_n   = '0;
		if (c_id) begin
			tm_alive_n = tm_hit;
			tm_len_n   = tm_base_len + 4'd1;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (tm_alive_q[k] && {1'b0, tm_len_q} == TM_LENS[k]) begin
					found_n = found_n | TM_FOUND[k];
				end
			end
		end
		tm_fin_n = '0;
		for (int k = 0; k < 3; k++) begin
			if (tm_alive_n[k] && {1'b0, tm_len_n} == TM_LENS[k]) begin
				tm_fin_n = tm_fin_n | TM_FOUND[k];
			end
		end

		bi_alive_n = bi_alive_q;
		bi_len_n   = bi_len_q;
		bi_gap_n   = bi_gap_q;
		gap_r      = GAP_NONE;
		gap_apply  = 1'b0;
		if (bi_gap_q != GAP_NONE) begin
			gap_r     = gap_step(bi_gap_q, c);
			gap_apply = 1'b1;
		end else if (!c_id && bi_complete) begin
			gap_r     = gap_step(GAP_PLAIN, c);
			gap_apply = 1'b1;
		end else if (!c_id) begin
			bi_alive_n = '0;
		end
		if (gap_apply) begin
			case (gap_r)
				GAP_FOUND: begin
					found_n    = found_n | bi_kind;
					bi_gap_n   = GAP_NONE;
					bi_alive_n = '0;
				end
				GAP_NONE: begin
					bi_gap_n   = GAP_NONE;
					bi_alive_n = '0;
				end
				default: begin
					bi_gap_n = gap_r;
				end
			endcase
		end
		bi_base_alive = fresh ? 3'b111 : bi_alive_n;
		bi_base_len   = fresh ? 5'd0 : bi_len_n;
		for (int k = 0; k < 3; k++) begin
			bi_hit[k] = bi_base_alive[k] && (bi_base_len < BI_LENS[k])
				&& (char_at(BI_WORDS[k], bi_base_len) == c);
		end
		if (c_id) begin
			bi_alive_n = bi_hit;
			bi_len_n   = bi_base_len + 5'd1;
		end

		case (emb_q)
			EMB_BSLASH: begin
				emb_n = (c == CH_LF) ? EMB_GAP : ((c == CH_CR) ? EMB_BSLASH_CR : EMB_IDLE);
			end
			EMB_GAP, EMB_BSLASH_CR: begin
				if (emb_q == EMB_BSLASH_CR && c == CH_LF) begin
					emb_n = EMB_GAP;
				end else if (is_hspace(c)) begin
					emb_n = EMB_GAP;
				end else if (c == CH_BSLASH) begin
					emb_n = EMB_BSLASH;
				end else if (c == "e") begin
					emb_n = EMB_E;
				end else begin
					emb_n = EMB_IDLE;
				end
			end
			EMB_E:    emb_n = (c == "m") ? EMB_EM : EMB_IDLE;
			EMB_EM:   emb_n = (c == "b") ? EMB_EMB : EMB_IDLE;
			EMB_EMB:  emb_n = (c == "e") ? EMB_EMBE : EMB_IDLE;
			EMB_EMBE: emb_n = (c == "d") ? EMB_EMBED : EMB_IDLE;
			EMB_EMBED: begin
				if (!c_id) begin
					found_n = found_n | FLAG_EMBED;
				end
				emb_n = EMB_IDLE;
			end
			default: emb_n = EMB_IDLE;
		endcase
		if (c == CH_HASH) begin
			emb_n = EMB_GAP;
		end

		case (inc_q)
			INC_DOT:   inc_n = (c == "i") ? INC_I : INC_IDLE;
			INC_I:     inc_n = (c == "n") ? INC_IN : INC_IDLE;
			INC_IN:    inc_n = (c == "c") ? INC_INC : INC_IDLE;
			INC_INC:   inc_n = (c == "b") ? INC_INCB : INC_IDLE;
			INC_INCB:  inc_n = (c == "i") ? INC_INCBI : INC_IDLE;
			INC_INCBI: inc_n = (c == "n") ? INC_INCBIN : INC_IDLE;
			INC_INCBIN: begin
				if (is_hspace(c)) begin
					inc_n = INC_INCBIN;
				end else if (c == CH_BSLASH) begin
					inc_n = INC_BSLASH;
				end else begin
					if (c == CH_QUOTE) begin
						found_n = found_n | FLAG_INCBIN;
					end
					inc_n = INC_IDLE;
				end
			end
			INC_BSLASH: begin
				if (c == CH_QUOTE) begin
					found_n = found_n | FLAG_INCBIN;
				end
				inc_n = INC_IDLE;
			end
			default: inc_n = INC_IDLE;
		endcase
		if (c == CH_DOT) begin
			inc_n = INC_DOT;
		end

		found_final = found_n | (c_id ? tm_fin_n : '0)
			| ((emb_n == EMB_EMBED) ? FLAG_EMBED : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= '0;
			prev_q     <= 1'b0;
			tm_alive_q <= '0;
			tm_len_q   <= '0;
			bi_alive_q <= '0;
			bi_len_q   <= '0;
			bi_gap_q   <= GAP_NONE;
			emb_q      <= EMB_IDLE;
			inc_q      <= INC_IDLE;
		end else if (step.valid) begin
			if (step.last) begin
				found_q    <= '0;
				prev_q     <= 1'b0;
				tm_alive_q <= '0;
				tm_len_q   <= '0;
				bi_alive_q <= '0;
				bi_len_q   <= '0;
				bi_gap_q   <= GAP_NONE;
				emb_q      <= EMB_IDLE;
				inc_q      <= INC_IDLE;
			end else begin
				found_q    <= found_n;
				prev_q     <= c_id;
				tm_alive_q <= tm_alive_n;
				tm_len_q   <= tm_len_n;
				bi_alive_q <= bi_alive_n;
				bi_len_q   <= bi_len_n;
				bi_gap_q   <= bi_gap_n;
				emb_q      <= emb_n;
				inc_q      <= inc_n;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_gap_needs_name: assert property (@(posedge clk) disable iff (!arst_n)
		bi_gap_q != GAP_NONE |-> bi_complete)
		else $error("builtin gap pending without a complete name");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && step.last |=> found_q == '0 && emb_q == EMB_IDLE
			&& inc_q == INC_IDLE && bi_gap_q == GAP_NONE && !prev_q)
		else $error("scanner state not cleared after final beat");

	a_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && !step.last |=> (found_q & $past(found_q)) == $past(found_q))
		else $error("found flag dropped within a text");
`endif

endmodule

// ===== hw/rtl/source_pattern_scanner.sv =====
// Top level of the source pattern scanner: input stage, scan core and result register.
// Takes one byte of source text per cycle on the input stream and, once the beat marked tlast
// has passed the input register and the scan core into the result register, presents the six
// found flags on the output stream (bit0 __DATE__, bit1 __TIME__, bit2 __TIMESTAMP__, bit3
// has-include builtin invoked, bit4 has-embed builtin invoked or #embed, bit5 .incbin
// followed by a quote). Every matcher advances combinationally from the current byte, so
// the sustained rate is one byte per cycle; the input stalls only when a final beat finds the
// single result register still holding an earlier, untaken result.
module source_pattern_scanner
	import sps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [5:0] found_set, [7:6] zero
);

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} beat_t;

	beat_t     beat_s1;
	logic      valid_s1;
	logic      advance;
	found_t    result_q;
	logic      out_valid_q;
	found_t    scan_found;
	sps_step_t step;

	assign advance = valid_s1 && (!beat_s1.last || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign step.valid = advance;
	assign step.last  = beat_s1.last;
	assign step.data  = beat_s1.data;

	sps_scan_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.found_final (scan_found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			beat_s1.data <= s_axis_tdata;
			beat_s1.last <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && beat_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.last) begin
			result_q <= scan_found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, result_q};

`ifndef NO_ASSERTIONS
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.last |=> m_axis_tvalid && m_axis_tdata[5:0] == $past(scan_found))
		else $error("final beat did not load the result register");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(beat_s1))
		else $error("stalled input stage lost its beat");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(advance && beat_s1.last))
		else $error("result raised without a final beat");
`endif

endmodule

// ===== tb/sv/source_pattern_scanner_test.sv =====
// Self-checking stream testbench for the source pattern scanner, with its own scan predictor.
module source_pattern_scanner_test
	import sps_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SRC_IDLE [4] = '{0, 66, 0, 24};
	localparam int SNK_STALL [4] = '{0, 0, 66, 24};
	localparam int HOLD_CYCLES = 250;
	localparam string HAS_PREFIX = "__has_";

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] data_byte
	logic       s_axis_tlast = 1'b0; // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [5:0] found_set

	logic [8:0] pending_beats [$];   // {last_byte, data_byte}
	found_t     found_expected [$];
	logic [7:0] text_buf [$];

	int src_idle = 0;
	int snk_stall = 0;
	logic hold_trigger = 1'b0;
	int hold_left = 0;

	int bad_results = 0;
	int results_checked = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	found_t flags_seen = '0;
	found_t want;
	logic byte_emits;
	found_t byte_flags;

	// scan state: sticky flags, identifier tries, builtin gap, directive progress
	found_t found_acc = '0;
	logic prev_id = 1'b0;
	logic tm_on = 1'b0;
	int tm_k = 0;
	int tm_n = 0;
	logic bi_on = 1'b0;
	int bi_k = 0;
	int bi_n = 0;
	gap_t bi_gap = GAP_NONE;
	int emb_st = 0; // 1..3 gap after '#', 4..8 letters of embed
	int inc_st = 0; // 1..7 letters of .incbin, 8 backslash after it

	source_pattern_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic string word_of(input logic grp, input int k);
		if (!grp) begin
			case (k)
			0: return "__DATE__";
			1: return "__TIME__";
			default: return "__TIMESTAMP__";
			endcase
		end
		case (k)
		0: return {HAS_PREFIX, "include"};
		1: return {HAS_PREFIX, "include_next"};
		default: return {HAS_PREFIX, "embed"};
		endcase
	endfunction

	function automatic logic ident_char(input logic [7:0] c);
		return c == CH_UNDER || (c >= "0" && c <= "9") || (c >= "a" && c <= "z")
			|| (c >= "A" && c <= "Z");
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB;
	endfunction

	// extend the identifier matched so far by one char; first word in list order wins
	function automatic logic word_step(input logic grp, input int cur, input int have,
			input logic [7:0] c, output int nxt);
		string w, p;
		logic ok;
		nxt = 0;
		p = word_of(grp, cur);
		for (int k = 0; k < 3; k++) begin
			w = word_of(grp, k);
			ok = have < w.len() && w[have] == c;
			for (int i = 0; i < have; i++) begin
				if (w[i] != p[i]) ok = 1'b0;
			end
			if (ok) begin
				nxt = k;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic gap_t cont_next(input gap_t g, input logic [7:0] c);
		if (g == GAP_BSLASH) begin
			if (c == CH_LF) return GAP_PLAIN;
			if (c == CH_CR) return GAP_BSLASH_CR;
			return GAP_NONE;
		end
		if (g == GAP_BSLASH_CR && c == CH_LF) return GAP_PLAIN;
		if (blank_char(c)) return GAP_PLAIN;
		if (c == CH_BSLASH) return GAP_BSLASH;
		if (c == CH_LPAREN) return GAP_FOUND;
		return GAP_NONE;
	endfunction

	function automatic void clear_scan();
		found_acc = '0;
		prev_id = 1'b0;
		tm_on = 1'b0;
		tm_k = 0;
		tm_n = 0;
		bi_on = 1'b0;
		bi_k = 0;
		bi_n = 0;
		bi_gap = GAP_NONE;
		emb_st = 0;
		inc_st = 0;
	endfunction

	function automatic void temporal_close();
		if (tm_on && tm_n == word_of(1'b0, tm_k).len()) found_acc[tm_k] = 1'b1;
	endfunction

	function automatic void builtin_gap_take(input gap_t r);
		if (r == GAP_FOUND) begin
			found_acc |= (bi_k == 2) ? FLAG_EMBED : FLAG_INCL;
			bi_gap = GAP_NONE;
			bi_on = 1'b0;
		end else if (r != GAP_NONE) begin
			bi_gap = r;
		end else begin
			bi_gap = GAP_NONE;
			bi_on = 1'b0;
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] c, input logic fin,
			output logic emit, output found_t flags);
		string embed_word, incbin_word;
		logic id, fresh, used;
		int e, b, nk;
		embed_word = "embed";
		incbin_word = ".incbin";
		id = ident_char(c);
		fresh = !prev_id;
		used = 1'b0;
		e = emb_st;
		b = inc_st;
		emit = 1'b0;
		flags = '0;

		if (id) begin
			if (fresh) begin
				tm_on = word_step(1'b0, 0, 0, c, nk);
				tm_k = nk;
				tm_n = 1;
			end else if (tm_on) begin
				tm_on = word_step(1'b0, tm_k, tm_n, c, nk);
				tm_k = nk;
				tm_n = tm_n + 1;
			end
		end else begin
			temporal_close();
			tm_on = 1'b0;
		end

		if (bi_gap != GAP_NONE) begin
			builtin_gap_take(cont_next(bi_gap, c));
			used = 1'b1;
		end
		if (id) begin
			if (fresh) begin
				bi_on = word_step(1'b1, 0, 0, c, nk);
				bi_k = nk;
				bi_n = 1;
			end else if (bi_on) begin
				bi_on = word_step(1'b1, bi_k, bi_n, c, nk);
				bi_k = nk;
				bi_n = bi_n + 1;
			end
		end else if (!used) begin
			if (bi_on && bi_n == word_of(1'b1, bi_k).len()) begin
				builtin_gap_take(cont_next(GAP_PLAIN, c));
			end else begin
				bi_on = 1'b0;
			end
		end

		if (e == 2) begin
			e = (c == CH_LF) ? 1 : ((c == CH_CR) ? 3 : 0);
		end else if (e == 3 && c == CH_LF) begin
			e = 1;
		end else if (e == 1 || e == 3) begin
			e = blank_char(c) ? 1 : ((c == CH_BSLASH) ? 2 : ((c == "e") ? 4 : 0));
		end else if (e >= 4 && e <= 7) begin
			e = (c == embed_word[e-3]) ? e + 1 : 0;
		end else if (e == 8) begin
			if (!id) found_acc |= FLAG_EMBED;
			e = 0;
		end else begin
			e = 0;
		end
		if (c == CH_HASH) e = 1;
		emb_st = e;

		if (b >= 1 && b <= 6) begin
			b = (c == incbin_word[b]) ? b + 1 : 0;
		end else if (b == 7) begin
			if (blank_char(c)) begin
				b = 7;
			end else if (c == CH_BSLASH) begin
				b = 8;
			end else begin
				if (c == CH_QUOTE) found_acc |= FLAG_INCBIN;
				b = 0;
			end
		end else if (b == 8) begin
			if (c == CH_QUOTE) found_acc |= FLAG_INCBIN;
			b = 0;
		end else begin
			b = 0;
		end
		if (c == CH_DOT) b = 1;
		inc_st = b;

		prev_id = id;

		if (fin) begin
			if (id) temporal_close();
			if (emb_st == 8) found_acc |= FLAG_EMBED;
			emit = 1'b1;
			flags = found_acc;
			clear_scan();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			clear_scan();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				scan_byte(s_axis_tdata, s_axis_tlast, byte_emits, byte_flags);
				if (byte_emits) found_expected.insert(found_expected.size(), byte_flags);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_beats.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
					s_axis_tvalid <= 1'b1;
					{s_axis_tlast, s_axis_tdata} <= pending_beats.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (found_expected.size() == 0) begin
					bad_results++;
					if (bad_results <= 10) $display("unexpected flag set %06b", m_axis_tdata[5:0]);
				end else begin
					want = found_expected.pop_front();
					results_checked++;
					flags_seen |= want;
					if (m_axis_tdata[5:0] !== want) begin
						bad_results++;
						if (bad_results <= 10) begin
							$display("flag set %0d: expected %06b, got %06b", results_checked, want,
								m_axis_tdata[5:0]);
						end
					end
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_stall);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_trigger) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic add_byte(input logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
	endtask

	task automatic add_gap();
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 4))
			0: add_str(" ");
			1: add_str("\t");
			2: add_str("\\\n");
			3: add_str("\\\r");
			default: add_str("\\\r\n");
			endcase
		end
	endtask

	function automatic logic [7:0] ident_rand();
		case ($urandom_range(0, 4))
		0: return CH_UNDER;
		1: return 8'h61 + 8'($urandom_range(0, 25));
		2: return 8'h41 + 8'($urandom_range(0, 25));
		3: return 8'h30 + 8'($urandom_range(0, 9));
		default: return "e";
		endcase
	endfunction

	task automatic add_fragment();
		int k;
		string w;
		k = $urandom_range(0, 2);
		case ($urandom_range(0, 9))
		0, 1: begin
			w = word_of(1'b0, k);
			if ($urandom_range(0, 3) == 0) w = w.substr(0, $urandom_range(0, w.len() - 2));
			add_str(w);
		end
		2: begin
			add_str(word_of(1'b1, k));
			add_gap();
			if ($urandom_range(0, 3) != 0) add_str("(");
			else add_byte(8'($urandom_range(0, 255)));
		end
		3: begin
			add_str("#");
			add_gap();
			add_str("embed");
			case ($urandom_range(0, 3))
			0: add_str(" ");
			1: add_byte(ident_rand());
			2: add_str("(");
			default: ;
			endcase
		end
		4: begin
			add_str(".incbin");
			repeat ($urandom_range(0, 2)) add_str($urandom_range(0, 1) ? " " : "\t");
			case ($urandom_range(0, 2))
			0: add_str("\"");
			1: add_str("\\\"");
			default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
		5: begin
			repeat ($urandom_range(1, 4)) add_byte(ident_rand());
		end
		6: begin
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
		end
		7: begin
			w = " \n(#.;\\\"";
			add_byte(w[$urandom_range(0, w.len() - 1)]);
		end
		8: begin
			if ($urandom_range(0, 1)) add_str("#em#embed");
			else add_str(".inc.incbin\"");
		end
		default: begin
			// backslash that does not continue the line
			add_str(word_of(1'b1, k));
			add_str("\\");
			add_byte(ident_rand());
			add_str("(");
		end
		endcase
	endtask

	task automatic ship_text();
		int n;
		if (text_buf.size() == 0) text_buf.insert(0, 8'($urandom_range(0, 255)));
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			pending_beats.insert(pending_beats.size(), {i == n - 1, text_buf[i]});
		end
		bytes_sent += n;
		texts_sent++;
		text_buf.delete();
	endtask

	task automatic random_text();
		repeat ($urandom_range(1, 3)) begin
			add_fragment();
			if ($urandom_range(0, 2) == 0) add_str(" ");
		end
		if ($urandom_range(0, 7) == 0 && text_buf.size() != 0) begin
			text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end
		ship_text();
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_beats.size() != 0 || s_axis_tvalid || found_expected.size() != 0);
	endtask

	initial begin
		int start_bytes, start_texts;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			src_idle = SRC_IDLE[ph];
			snk_stall = SNK_STALL[ph];
			if (ph == 0) begin
				add_str("__DATE__");
				ship_text();
				add_str("#em#embed");
				ship_text();
				add_byte(8'h00);
				add_byte(8'hff);
				ship_text();
				add_str({HAS_PREFIX, "embed\\\r("});
				ship_text();
				add_str(".incbin\\\"");
				ship_text();
				add_str({HAS_PREFIX, "include"});
				ship_text();
			end
			start_bytes = bytes_sent;
			start_texts = texts_sent;
			while (bytes_sent - start_bytes < 60 || texts_sent - start_texts < 3) random_text();
			drain();
		end

		// long receiver hold while short texts keep arriving
		@(negedge clk);
		src_idle = 0;
		snk_stall = 0;
		hold_trigger = 1'b1;
		repeat (8) begin
			add_fragment();
			ship_text();
		end
		@(negedge clk);
		hold_trigger = 1'b0;
		drain();

		repeat (20) @(negedge clk);
		$display("scanned %0d bytes in %0d texts, %0d flag sets compared, flags raised %06b",
			bytes_sent, texts_sent, results_checked, flags_seen);
		$display("idle mixes: none, sender, receiver, both, plus one long receiver hold");
		if (bad_results == 0 && found_expected.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#400us;
		$display("tb: failure");
		$finish;
	end

endmodule
